// ----- rtl/reorder_ring_buffer_unit_macros.svh -----
// Assertion helpers shared by the reorder ring buffer modules.
// Each macro expects clk and rst_n in scope and is disabled during reset.
`ifndef REORDER_RING_BUFFER_UNIT_MACROS_SVH
`define REORDER_RING_BUFFER_UNIT_MACROS_SVH

// Condition that holds at every clock edge
`define RRB_ASSERT_ALW(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication
`define RRB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RRB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rrb_pkg.sv -----
package rrb_pkg;

    // Ring geometry
    localparam int DEPTH         = 64;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CAP_W         = $clog2(DEPTH + 1);
    localparam int PKT_WIDTH_DEF = 32;

    // Field widths
    localparam int CFG_W  = 7;
    localparam int OFF_W  = 7;
    localparam int SPAN_W = 6;
    localparam int CNT_W  = 6;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_PEEK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OCCUPIED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_COMMIT,
        S_READ,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic plan;
        logic commit;
        logic read;
        logic load;
    } cmd_t;

endpackage

// ----- rtl/rrb_req_if.sv -----
interface rrb_req_if #(
    parameter int PKT_WIDTH = rrb_pkg::PKT_WIDTH_DEF
);
    import rrb_pkg::*;

    logic                   valid;
    logic                   ready;
    action_t                action;
    logic signed [OFF_W-1:0] offset;
    logic [PKT_WIDTH-1:0]   packet;

    modport source (output valid, output action, output offset, output packet, input ready);
    modport sink   (input valid, input action, input offset, input packet, output ready);

endinterface

// ----- rtl/rrb_rsp_if.sv -----
interface rrb_rsp_if #(
    parameter int PKT_WIDTH = rrb_pkg::PKT_WIDTH_DEF
);
    import rrb_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic                 head_valid;
    logic                 head_filled;
    logic [PKT_WIDTH-1:0] head_packet;
    logic [SPAN_W-1:0]    span;
    logic [CNT_W-1:0]     stored_count;

    modport source (
        output valid, output status, output head_valid, output head_filled,
        output head_packet, output span, output stored_count, input ready
    );
    modport sink (
        input valid, input status, input head_valid, input head_filled,
        input head_packet, input span, input stored_count, output ready
    );

endinterface

// ----- rtl/rrb_ram.sv -----
module rrb_ram #(
    parameter int WIDTH = rrb_pkg::PKT_WIDTH_DEF,
    parameter int DEPTH = rrb_pkg::DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/rrb_ctrl.sv -----
module rrb_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output rrb_pkg::cmd_t cmd
);
    import rrb_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PLAN;
                end
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // result register free or being drained this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`include "reorder_ring_buffer_unit_macros.svh"

    `RRB_ASSERT_IMP(a_load_needs_room, cmd.load, !out_valid_reg || out_ready, "result overwritten while stalled")
    `RRB_ASSERT_NXT(a_commit_follows_plan, cmd.plan, cmd.commit, "commit did not follow plan")
    `RRB_ASSERT_ALW(a_cmd_exclusive, $onehot0(cmd), "more than one datapath command active")

endmodule

// ----- rtl/rrb_datapath.sv -----
module rrb_datapath #(
    parameter int PKT_WIDTH = rrb_pkg::PKT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rrb_pkg::CFG_W-1:0]     cfg_data,
    input  rrb_pkg::cmd_t                 cmd,
    input  rrb_pkg::action_t              action,
    input  logic signed [rrb_pkg::OFF_W-1:0] offset,
    input  logic [PKT_WIDTH-1:0]          packet,
    output rrb_pkg::status_t              status,
    output logic                          head_valid,
    output logic                          head_filled,
    output logic [PKT_WIDTH-1:0]          head_packet,
    output logic [rrb_pkg::SPAN_W-1:0]    span,
    output logic [rrb_pkg::CNT_W-1:0]     stored_count
);
    import rrb_pkg::*;

    // Room for index + capacity sums
    localparam int AW = CAP_W + 1;

    // Ring state
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [DEPTH-1:0] filled_reg, filled_next;

    // Captured request
    action_t              act_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [PKT_WIDTH-1:0] pkt_reg;

    // Plan results
    logic             ok_reg;
    logic [IDX_W-1:0] head_n_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] tail_n_reg;
    logic             tail_upd_reg;
    status_t          status_reg;

    // Result register
    status_t              out_status_reg;
    logic                 out_hv_reg;
    logic                 out_hf_reg;
    logic [PKT_WIDTH-1:0] out_pkt_reg;
    logic [SPAN_W-1:0]    out_span_reg;
    logic [CNT_W-1:0]     out_cnt_reg;

    // Plan datapath
    logic [AW-1:0]    h_w, t_w, c_w, span_w, mag_w, offu_w;
    logic [AW-1:0]    back_w, fwd_w, fwd_m, tnx_w, tnx_m;
    logic [OFF_W-1:0] mag_n;
    logic             neg, plan_ok, tail_upd_p;
    logic [IDX_W-1:0] head_p, slot_p, head_inc;
    logic [CAP_W-1:0] cap_eff;
    status_t          commit_status;

    logic                 ram_we;
    logic [PKT_WIDTH-1:0] ram_rdata;

    // Window arithmetic, all modulo the capacity
    always_comb
    begin
        h_w    = AW'(head_reg);
        t_w    = AW'(tail_reg);
        c_w    = AW'(cap_reg);
        span_w = (t_w >= h_w) ? (t_w - h_w) : (t_w + c_w - h_w);

        neg    = off_reg[OFF_W-1];
        // magnitude of a negative offset, 1..64, kept at the offset width
        mag_n  = OFF_W'(0) - off_reg;
        mag_w  = AW'(mag_n);
        offu_w = AW'(off_reg);

        // head moved back; growth check guarantees mag < cap
        back_w = (h_w >= mag_w) ? (h_w - mag_w) : (h_w + c_w - mag_w);
        fwd_w  = h_w + offu_w;
        fwd_m  = (fwd_w >= c_w) ? (fwd_w - c_w) : fwd_w;
        tnx_w  = fwd_w + AW'(1);
        tnx_m  = (tnx_w >= c_w) ? (tnx_w - c_w) : tnx_w;

        plan_ok    = neg ? ((span_w + mag_w) < c_w) : (offu_w < (c_w - AW'(1)));
        head_p     = neg ? back_w[IDX_W-1:0] : head_reg;
        slot_p     = neg ? back_w[IDX_W-1:0] : fwd_m[IDX_W-1:0];
        tail_upd_p = !neg && (offu_w >= span_w);

        head_inc = ((h_w + AW'(1)) >= c_w) ? '0 : (head_reg + IDX_W'(1));

        // clamp written capacity to the ring
        if (cfg_data < CFG_W'(2))
        begin
            cap_eff = CAP_W'(2);
        end
        else if (cfg_data > CFG_W'(DEPTH))
        begin
            cap_eff = CAP_W'(DEPTH);
        end
        else
        begin
            cap_eff = CAP_W'(cfg_data);
        end
    end

    // State update on commit or configuration write
    always_comb
    begin
        cap_next      = cap_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        filled_next   = filled_reg;
        commit_status = ST_DONE;
        ram_we        = 1'b0;

        if (cfg_we)
        begin
            cap_next    = cap_eff;
            head_next   = '0;
            tail_next   = '0;
            count_next  = '0;
            filled_next = '0;
        end
        else if (cmd.commit)
        begin
            unique case (act_reg)
                ACT_INSERT:
                begin
                    if (!ok_reg)
                    begin
                        commit_status = ST_RANGE;
                    end
                    else
                    begin
                        head_next = head_n_reg;
                        if (filled_reg[slot_reg])
                        begin
                            commit_status = ST_OCCUPIED;
                        end
                        else
                        begin
                            filled_next[slot_reg] = 1'b1;
                            count_next            = count_reg + IDX_W'(1);
                            ram_we                = 1'b1;
                            if (tail_upd_reg)
                            begin
                                tail_next = tail_n_reg;
                            end
                        end
                    end
                end
                ACT_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        commit_status = ST_EMPTY;
                    end
                    else
                    begin
                        if (filled_reg[head_reg])
                        begin
                            filled_next[head_reg] = 1'b0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - IDX_W'(1);
                            end
                        end
                        head_next = head_inc;
                    end
                end
                ACT_CLEAR:
                begin
                    head_next   = '0;
                    tail_next   = '0;
                    count_next  = '0;
                    filled_next = '0;
                end
                ACT_PEEK:
                begin
                    commit_status = ST_DONE;
                end
                default:
                begin
                    commit_status = ST_DONE;
                end
            endcase
        end
    end

    // Ring state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_W'(DEPTH);
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            filled_reg <= '0;
        end
        else
        begin
            cap_reg    <= cap_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            filled_reg <= filled_next;
        end
    end

    // Request capture, plan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            off_reg <= offset;
            pkt_reg <= packet;
        end
        if (cmd.plan)
        begin
            ok_reg       <= plan_ok;
            head_n_reg   <= head_p;
            slot_reg     <= slot_p;
            tail_n_reg   <= tnx_m[IDX_W-1:0];
            tail_upd_reg <= tail_upd_p;
        end
        if (cmd.commit)
        begin
            status_reg <= commit_status;
        end
        if (cmd.load)
        begin
            out_status_reg <= status_reg;
            out_hv_reg     <= (head_reg != tail_reg);
            out_hf_reg     <= (head_reg != tail_reg) && filled_reg[head_reg];
            out_pkt_reg    <= ((head_reg != tail_reg) && filled_reg[head_reg]) ? ram_rdata : '0;
            out_span_reg   <= span_w[SPAN_W-1:0];
            out_cnt_reg    <= count_reg[CNT_W-1:0];
        end
    end

    // Slot descriptor store
    rrb_ram #(
        .WIDTH (PKT_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (pkt_reg),
        .re    (cmd.read),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign status       = out_status_reg;
    assign head_valid   = out_hv_reg;
    assign head_filled  = out_hf_reg;
    assign head_packet  = out_pkt_reg;
    assign span         = out_span_reg;
    assign stored_count = out_cnt_reg;

`include "reorder_ring_buffer_unit_macros.svh"

    `RRB_ASSERT_ALW(a_count_matches, $countones(filled_reg) == count_reg, "fill count out of step with slot flags")
    `RRB_ASSERT_ALW(a_index_range, (AW'(head_reg) < AW'(cap_reg)) && (AW'(tail_reg) < AW'(cap_reg)), "ring index beyond capacity")
    `RRB_ASSERT_IMP(a_write_empty_slot, ram_we, !filled_reg[slot_reg], "descriptor written over a filled slot")

endmodule

// ----- rtl/reorder_ring_buffer_unit.sv -----
// Reorder ring buffer: holds packet descriptors in a window of ring slots.
// Request channel (req): action, signed offset from the head, packet.
//   insert fills the slot at head+offset (negative offsets grow the window
//   downward), pop retires the head slot, clear empties, peek reports only.
// Response channel (rsp): one response per request with a status and the
//   head state after the request (valid, filled, descriptor, span, count).
// Configuration: cfg_we/cfg_data write the capacity (clamped to 2..64) and
//   empty the buffer; write only while the block is idle.
// Timing: a request is taken in the idle state and runs plan, commit and
//   slot read steps before its response is loaded in the done step. The
//   sequencer handles one request at a time; the slot read step serves
//   the registered read of the descriptor RAM after the slot update.
// A finished response sits in an output register; the next request is
//   accepted while it waits. If rsp is stalled, the following response
//   waits in the done step until the register drains.
// Reset (rst_n, asynchronous, active low): empty window, capacity 64,
//   no response pending. The descriptor RAM is not cleared; slot flags are.
module reorder_ring_buffer_unit #(
    parameter int PKT_WIDTH = rrb_pkg::PKT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rrb_pkg::CFG_W-1:0] cfg_data,
    rrb_req_if.sink                   req,
    rrb_rsp_if.source                 rsp
);
    import rrb_pkg::*;

    cmd_t cmd;

    // Sequencer
    rrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Ring state, slot store and result register
    rrb_datapath #(
        .PKT_WIDTH (PKT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .action       (req.action),
        .offset       (req.offset),
        .packet       (req.packet),
        .status       (rsp.status),
        .head_valid   (rsp.head_valid),
        .head_filled  (rsp.head_filled),
        .head_packet  (rsp.head_packet),
        .span         (rsp.span),
        .stored_count (rsp.stored_count)
    );

endmodule

// ----- bench/rrb_window_checker.sv -----
module rrb_window_checker #(
    parameter int PKT_WIDTH = rrb_pkg::PKT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rrb_pkg::CFG_W-1:0] cfg_data,
    rrb_req_if                        req,
    rrb_rsp_if                        rsp,
    output int                        fail_count,
    output int                        pending,
    output int                        checked,
    output int                        rejected
);
    import rrb_pkg::*;

    // What one response should carry
    typedef struct packed {
        status_t              status;
        logic                 head_valid;
        logic                 head_filled;
        logic [PKT_WIDTH-1:0] head_packet;
        logic [SPAN_W-1:0]    span;
        logic [CNT_W-1:0]     stored_count;
    } head_report_t;

    // Shadow copy of the ring
    logic [PKT_WIDTH-1:0] slot_pkt [DEPTH];
    bit                   slot_full [DEPTH];
    int                   head_idx;
    int                   tail_idx;
    int                   filled;
    int                   cap_reg;

    head_report_t head_reports [$];

    // Written capacity clamped to the legal ring size
    function automatic int ring_size();
        if (cap_reg < 2)
        begin
            return 2;
        end
        if (cap_reg > DEPTH)
        begin
            return DEPTH;
        end
        return cap_reg;
    endfunction

    function automatic int window_span(input int cap);
        return (tail_idx + cap - head_idx) % cap;
    endfunction

    function automatic void empty_window();
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_full[i] = 1'b0;
        end
        head_idx = 0;
        tail_idx = 0;
        filled   = 0;
    endfunction

    // Apply one request to the shadow ring and return the head report after it
    function automatic head_report_t advance_window(
        input action_t                  act,
        input logic signed [OFF_W-1:0]  off,
        input logic [PKT_WIDTH-1:0]     pkt
    );
        int           cap;
        int           sp;
        int           o;
        int           idx;
        int           slot;
        bit           ok;
        head_report_t r;

        cap      = ring_size();
        o        = off;
        r.status = ST_DONE;
        case (act)
            ACT_INSERT:
            begin
                sp  = window_span(cap);
                ok  = 1'b1;
                idx = 0;
                // negative offset grows the window downward if it still fits
                if (o < 0)
                begin
                    if (sp - o < cap)
                    begin
                        head_idx = (head_idx + cap + o) % cap;
                    end
                    else
                    begin
                        ok       = 1'b0;
                        r.status = ST_RANGE;
                    end
                end
                else if (o >= cap - 1)
                begin
                    ok       = 1'b0;
                    r.status = ST_RANGE;
                end
                else
                begin
                    idx = o;
                end
                if (ok)
                begin
                    slot = (head_idx + idx) % cap;
                    if (slot_full[slot])
                    begin
                        r.status = ST_OCCUPIED;
                    end
                    else
                    begin
                        slot_pkt[slot]  = pkt;
                        slot_full[slot] = 1'b1;
                        filled++;
                        // slot past the tail drags the tail along
                        if (idx >= window_span(cap))
                        begin
                            tail_idx = (head_idx + idx + 1) % cap;
                        end
                    end
                end
            end
            ACT_POP:
            begin
                if (head_idx == tail_idx)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // a hole retires without touching the count
                    if (slot_full[head_idx])
                    begin
                        slot_full[head_idx] = 1'b0;
                        if (filled > 0)
                        begin
                            filled--;
                        end
                    end
                    head_idx = (head_idx + 1) % cap;
                end
            end
            ACT_CLEAR:
            begin
                empty_window();
            end
            default:
            begin
            end
        endcase

        r.head_valid   = head_idx != tail_idx;
        r.head_filled  = r.head_valid && slot_full[head_idx];
        r.head_packet  = r.head_filled ? slot_pkt[head_idx] : '0;
        r.span         = SPAN_W'(window_span(cap));
        r.stored_count = CNT_W'(filled);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] response %0d: %s got %h, want %h", $time, checked, field, got, want);
        fail_count++;
    endtask

    task automatic compare_head_report(input head_report_t want);
        if (rsp.status !== want.status)
        begin
            report_mismatch("status", rsp.status, want.status);
        end
        if (rsp.head_valid !== want.head_valid)
        begin
            report_mismatch("head_valid", rsp.head_valid, want.head_valid);
        end
        if (rsp.head_filled !== want.head_filled)
        begin
            report_mismatch("head_filled", rsp.head_filled, want.head_filled);
        end
        if (rsp.head_packet !== want.head_packet)
        begin
            report_mismatch("head_packet", rsp.head_packet, want.head_packet);
        end
        if (rsp.span !== want.span)
        begin
            report_mismatch("span", rsp.span, want.span);
        end
        if (rsp.stored_count !== want.stored_count)
        begin
            report_mismatch("stored_count", rsp.stored_count, want.stored_count);
        end
        if (want.status != ST_DONE)
        begin
            rejected++;
        end
        checked++;
    endtask

    // Watch config, request and response traffic at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_window();
            cap_reg = DEPTH;
            head_reports.delete();
            pending <= 0;
        end
        else
        begin
            // capacity write also empties the ring
            if (cfg_we)
            begin
                cap_reg = cfg_data;
                empty_window();
            end
            if (req.valid && req.ready)
            begin
                head_reports.push_back(advance_window(req.action, req.offset, req.packet));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (head_reports.size() == 0)
                begin
                    report_mismatch("response with no request outstanding", rsp.status, '0);
                end
                else
                begin
                    compare_head_report(head_reports.pop_front());
                end
            end
            pending <= head_reports.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    import rrb_pkg::*;

    localparam int RUN_LIMIT  = 200000;
    localparam int LONG_HOLD  = 80;
    localparam int DRAIN_TAIL = 20;
    localparam int PHASES     = 9;
    localparam int PHASE_REQS = 100;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    int cycles = 0;
    int send_idle_pct;
    int rsp_stall_pct;
    int hold_asks;
    int hold_done = 0;
    int hold_left = 0;
    int settings_used = 1;
    int eff_cap;
    int fail_count;
    int pending;
    int checked;
    int rejected;

    // capacity per random phase; 0, 1, 65 and 127 are clamped by the block
    logic [CFG_W-1:0] phase_caps [PHASES] = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd33,
                                              7'd1, 7'd65, 7'd12, 7'd64};

    rrb_req_if req_ch ();
    rrb_rsp_if rsp_ch ();

    reorder_ring_buffer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    rrb_window_checker window_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .rejected   (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold when asked
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_done != hold_asks)
            begin
                hold_done++;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic send_req(input action_t act, input int off, input logic [31:0] pkt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.offset <= off[OFF_W-1:0];
        req_ch.packet <= pkt;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop offering and wait until every response is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Stimulus and verdict
    initial
    begin
        int      roll;
        action_t act;
        int      off;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_PEEK;
        req_ch.offset <= '0;
        req_ch.packet <= '0;
        send_idle_pct = 0;
        rsp_stall_pct <= 0;
        hold_asks     <= 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full ring of 64
        send_req(ACT_PEEK,    0,   32'h0);
        send_req(ACT_POP,     0,   32'h0);            // pop on empty
        send_req(ACT_INSERT,  0,   32'hFFFF_FFFF);
        send_req(ACT_INSERT,  0,   32'h1234_5678);    // slot already filled
        send_req(ACT_INSERT,  5,   32'h0);            // past the tail
        send_req(ACT_INSERT,  62,  32'hA5A5_A5A5);    // largest legal offset
        send_req(ACT_INSERT,  63,  32'h0);            // offset too large
        send_req(ACT_INSERT,  -1,  32'h0);            // no room to grow down
        send_req(ACT_POP,     0,   32'h0);            // retire a packet
        send_req(ACT_POP,     0,   32'h0);            // retire a hole
        send_req(ACT_INSERT,  -2,  32'h5A5A_5A5A);    // grow down
        send_req(ACT_INSERT,  -64, 32'h0);
        send_req(ACT_PEEK,    0,   32'h0);
        send_req(ACT_CLEAR,   0,   32'h0);
        send_req(ACT_INSERT,  -64, 32'hDEAD_BEEF);    // too deep on empty ring
        send_req(ACT_INSERT,  -63, 32'hC0DE_0001);    // head wraps around
        send_req(ACT_POP,     0,   32'h0);
        send_req(ACT_CLEAR,   0,   32'h0);

        // directed: smallest ring
        write_capacity(7'd2);
        send_req(ACT_INSERT,  0,   32'h0000_0011);
        send_req(ACT_INSERT,  1,   32'h0000_0022);    // offset at capacity minus one
        send_req(ACT_INSERT,  -1,  32'h0000_0033);    // span would reach capacity
        send_req(ACT_POP,     0,   32'h0);
        send_req(ACT_INSERT,  -1,  32'h0000_0044);    // grow down from empty
        send_req(ACT_POP,     0,   32'h0);
        send_req(ACT_POP,     0,   32'h0);

        // random phases over capacities and idle mixes
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            eff_cap = (phase_caps[p] < 2) ? 2 : ((phase_caps[p] > DEPTH) ? DEPTH : phase_caps[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 56;
                    rsp_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct <= 56;
                end
                default:
                begin
                    send_idle_pct = 13;
                    rsp_stall_pct <= 13;
                end
            endcase
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                // long output hold while requests keep coming
                if (p == 0 && n == 30)
                begin
                    hold_asks <= hold_asks + 1;
                end
                // sender pause until everything is back
                if (p == 5 && n == 50)
                begin
                    wait_drained();
                end
                roll = $urandom_range(99);
                if (roll < 50)
                begin
                    act = ACT_INSERT;
                end
                else if (roll < 85)
                begin
                    act = ACT_POP;
                end
                else if (roll < 97)
                begin
                    act = ACT_PEEK;
                end
                else
                begin
                    act = ACT_CLEAR;
                end
                // mostly near the head, some downward growth, some anything
                roll = $urandom_range(99);
                if (roll < 65)
                begin
                    off = $urandom_range((eff_cap - 2 < 6) ? eff_cap - 2 : 6);
                end
                else if (roll < 80)
                begin
                    off = -int'($urandom_range(3, 1));
                end
                else if (roll < 90)
                begin
                    off = $urandom_range(eff_cap - 1);
                end
                else
                begin
                    off = int'($urandom_range(127)) - 64;
                end
                send_req(act, off, $urandom);
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Covered %0d requests over %0d capacity settings, four idle/stall mixes",
                 checked, settings_used);
        $display("and a long output hold; %0d were range drops, occupied slots or empty pops.",
                 rejected);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rrb_pkg.sv
rtl/rrb_req_if.sv
rtl/rrb_rsp_if.sv
rtl/rrb_ram.sv
rtl/rrb_ctrl.sv
rtl/rrb_datapath.sv
rtl/reorder_ring_buffer_unit.sv
bench/rrb_window_checker.sv
bench/tb.sv
